[sv/sbme_pkg.sv]
`default_nettype none
package sbme_pkg;

   localparam int MAX_SIDE_DEF   = 256;
   localparam int MAX_MARGIN_DEF = 16;

   localparam int SIZE_W     = 9;
   localparam int MARGIN_W   = 5;
   localparam int COORD_W    = 8;
   localparam int PIX_W      = 8;
   localparam int SHIFT_W    = 7;
   localparam int COUNT_W    = 11;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = SIZE_W;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MARGIN     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SKIP_WHITE = 2'd2;

   localparam logic [SIZE_W-1:0]   IMAGE_SIZE_RST = 9'd256;
   localparam logic [MARGIN_W-1:0] MARGIN_RST     = 5'd4;

   localparam logic [PIX_W-1:0] WHITE = 8'd255;

   typedef enum logic {
      ACT_LOAD  = 1'b0,
      ACT_MATCH = 1'b1
   } action_type;

   typedef struct packed {
      logic [SIZE_W-1:0]   image_size;
      logic [MARGIN_W-1:0] margin;
      logic                skip_white;
   } csr_type;

   // For a load, out_of_range marks a position outside the store.
   typedef struct packed {
      action_type         action;
      logic               out_of_range;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic [PIX_W-1:0]   left_pixel;
      logic [PIX_W-1:0]   right_pixel;
   } item_type;

   function automatic int side_clamp(input int size, input int max_side);
      return (size > max_side) ? max_side : size;
   endfunction

   function automatic int margin_clamp(input int m, input int max_margin);
      int r;
      r = (m < 1) ? 1 : m;
      return (r > max_margin) ? max_margin : r;
   endfunction

endpackage
`default_nettype wire

[sv/stereo_block_match_equal_count.sv]
// Stereo block matcher. Load words write one left/right pixel pair into two
// MAX_SIDE x MAX_SIDE image memories; match words return one result word with
// the first row shift that gives the highest count of equal pixels over a
// 2*margin square window. Words enter a two-word queue, so the input keeps
// flowing while the matcher works, until both slots are full. A load is
// written in the idle state. A match outside the interior goes straight to its
// result; with skip_white set, an interior match is skipped if the left pixels
// at rows row-1..row, columns col-1..col are all white. A full match tries z row
// shifts, z = (image_size - 2*margin)/2, each memory giving one pixel per cycle.
// A result not taken stalls the matcher once its next result is ready. Image
// contents are undefined until written.
`default_nettype none
module stereo_block_match_equal_count #(
   parameter int MAX_SIDE   = sbme_pkg::MAX_SIDE_DEF,
   parameter int MAX_MARGIN = sbme_pkg::MAX_MARGIN_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_write_en,
   input  wire logic [sbme_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [sbme_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                            req_tvalid,
   output      logic                            req_tready,
   // row, col, left_pixel, right_pixel
   input  wire logic [31:0]                     req_tdata,
   // action
   input  wire logic [0:0]                      req_tuser,
   output      logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   // best_shift, best_count, zero padding
   output      logic [23:0]                     rsp_tdata,
   // skipped, out_of_range
   output      logic [1:0]                      rsp_tuser
);

   sbme_pkg::csr_type  cfg;
   sbme_pkg::item_type push_item, pop_item;
   logic push_valid, push_ready, pop_valid, pop_ready;
   logic [sbme_pkg::SHIFT_W-1:0] best_shift;
   logic [sbme_pkg::COUNT_W-1:0] best_count;
   logic skipped, out_of_range;

   sbme_front #(.MAX_SIDE(MAX_SIDE), .MAX_MARGIN(MAX_MARGIN)) u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_tvalid),
      .req_ready       (req_tready),
      .req_action      (sbme_pkg::action_type'(req_tuser[0])),
      .req_row         (req_tdata[7:0]),
      .req_col         (req_tdata[15:8]),
      .req_left_pixel  (req_tdata[23:16]),
      .req_right_pixel (req_tdata[31:24]),
      .cfg             (cfg),
      .push_valid      (push_valid),
      .push_ready      (push_ready),
      .push_item       (push_item)
   );

   sbme_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   sbme_back #(.MAX_SIDE(MAX_SIDE), .MAX_MARGIN(MAX_MARGIN)) u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .q_valid          (pop_valid),
      .q_ready          (pop_ready),
      .q_item           (pop_item),
      .rsp_valid        (rsp_tvalid),
      .rsp_ready        (rsp_tready),
      .rsp_best_shift   (best_shift),
      .rsp_best_count   (best_count),
      .rsp_skipped      (skipped),
      .rsp_out_of_range (out_of_range)
   );

   assign rsp_tdata = {6'd0, best_count, best_shift};
   assign rsp_tuser = {out_of_range, skipped};

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_of_range |-> (best_shift == '0) && (best_count == '0) && !skipped)
      else $error("out-of-range result carries a match");

   a_skip_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && skipped |-> (best_shift == '0) && (best_count == '0))
      else $error("skipped result carries a match");

   a_shift_needs_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (best_count == '0) |-> (best_shift == '0))
      else $error("nonzero shift without a count");

endmodule
`default_nettype wire

[sv/sbme_ram.sv]
`default_nettype none
module sbme_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[sv/sbme_front.sv]
`default_nettype none
module sbme_front #(
   parameter int MAX_SIDE   = sbme_pkg::MAX_SIDE_DEF,
   parameter int MAX_MARGIN = sbme_pkg::MAX_MARGIN_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_write_en,
   input  wire logic [sbme_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [sbme_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  wire logic                                 req_valid,
   output      logic                                 req_ready,
   input  wire sbme_pkg::action_type                 req_action,
   input  wire logic [sbme_pkg::COORD_W-1:0]         req_row,
   input  wire logic [sbme_pkg::COORD_W-1:0]         req_col,
   input  wire logic [sbme_pkg::PIX_W-1:0]           req_left_pixel,
   input  wire logic [sbme_pkg::PIX_W-1:0]           req_right_pixel,
   output      sbme_pkg::csr_type                    cfg,
   output      logic                                 push_valid,
   input  wire logic                                 push_ready,
   output      sbme_pkg::item_type                   push_item
);

   sbme_pkg::csr_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            sbme_pkg::REG_IMAGE_SIZE: cfg_in.image_size = csr_wdata;
            sbme_pkg::REG_MARGIN:     cfg_in.margin = csr_wdata[sbme_pkg::MARGIN_W-1:0];
            sbme_pkg::REG_SKIP_WHITE: cfg_in.skip_white = csr_wdata[0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_size <= sbme_pkg::IMAGE_SIZE_RST;
         cfg_ff.margin     <= sbme_pkg::MARGIN_RST;
         cfg_ff.skip_white <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

   always_comb begin
      int n;
      int m;
      int r;
      int c;
      n = sbme_pkg::side_clamp(int'(cfg_ff.image_size), MAX_SIDE);
      m = sbme_pkg::margin_clamp(int'(cfg_ff.margin), MAX_MARGIN);
      r = int'(req_row);
      c = int'(req_col);
      push_item.action      = req_action;
      push_item.row         = req_row;
      push_item.col         = req_col;
      push_item.left_pixel  = req_left_pixel;
      push_item.right_pixel = req_right_pixel;
      if (req_action == sbme_pkg::ACT_LOAD) begin
         push_item.out_of_range = (r >= MAX_SIDE) || (c >= MAX_SIDE);
      end else begin
         push_item.out_of_range = (n < 2 * m + 1) || (r < m) || (c < m) ||
                                  (r >= n - m) || (c >= n - m);
      end
   end

   assign push_valid = req_valid;
   assign req_ready  = push_ready;

endmodule
`default_nettype wire

[sv/sbme_queue.sv]
`default_nettype none
module sbme_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push_valid,
   output      logic               push_ready,
   input  wire sbme_pkg::item_type push_item,
   output      logic               pop_valid,
   input  wire logic               pop_ready,
   output      sbme_pkg::item_type pop_item
);

   localparam int DEPTH = sbme_pkg::QUEUE_DEPTH;
   localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW    = $clog2(DEPTH + 1);

   sbme_pkg::item_type slot_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign push_ready = (count_ff != NW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

[sv/sbme_back.sv]
`default_nettype none
module sbme_back #(
   parameter int MAX_SIDE   = sbme_pkg::MAX_SIDE_DEF,
   parameter int MAX_MARGIN = sbme_pkg::MAX_MARGIN_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire sbme_pkg::csr_type                cfg,
   input  wire logic                             q_valid,
   output      logic                             q_ready,
   input  wire sbme_pkg::item_type               q_item,
   output      logic                             rsp_valid,
   input  wire logic                             rsp_ready,
   output      logic [sbme_pkg::SHIFT_W-1:0]     rsp_best_shift,
   output      logic [sbme_pkg::COUNT_W-1:0]     rsp_best_count,
   output      logic                             rsp_skipped,
   output      logic                             rsp_out_of_range
);

   localparam int AW  = $clog2(MAX_SIDE * MAX_SIDE);
   localparam int CW  = $clog2(MAX_SIDE) + 1;
   localparam int OW  = (MAX_MARGIN > 1) ? $clog2(2 * MAX_MARGIN) : 1;
   localparam int SW  = $clog2(MAX_SIDE / 2 + 1);
   localparam int NCW = $clog2(4 * MAX_MARGIN * MAX_MARGIN + 1);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_WHITE = 5'b00010,
      ST_SCAN  = 5'b00100,
      ST_DRAIN = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   function automatic logic [AW-1:0] pix_addr(input int r, input int c);
      return AW'(r * MAX_SIDE + c);
   endfunction

   state_type state_ff, state_in;
   logic [CW-1:0]  row_ff, row_in, col_ff, col_in;
   logic           white_mode_ff, white_mode_in;
   logic [1:0]     k_ff, k_in;
   logic [SW-1:0]  s_ff, s_in;
   logic [OW-1:0]  io_ff, io_in, jo_ff, jo_in;
   logic           p_valid_ff, p_valid_in, p_use_ff, p_use_in;
   logic           p_end_ff, p_end_in;
   logic [SW-1:0]  p_shift_ff, p_shift_in;
   logic           allw_ff, allw_in;
   logic [NCW-1:0] cnt_ff, cnt_in, best_ff, best_in;
   logic [SW-1:0]  bests_ff, bests_in;
   logic [sbme_pkg::SHIFT_W-1:0] res_shift_ff, res_shift_in;
   logic [sbme_pkg::COUNT_W-1:0] res_count_ff, res_count_in;
   logic           res_skip_ff, res_skip_in, res_oor_ff, res_oor_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [sbme_pkg::SHIFT_W-1:0] rsp_shift_ff;
   logic [sbme_pkg::COUNT_W-1:0] rsp_count_ff;
   logic           rsp_skip_ff, rsp_oor_ff;

   logic [CW-1:0]  n_c, m_c, limit_c, li_c, lj_c, rr_c;
   logic [SW-1:0]  z_c;
   logic [OW-1:0]  win_last_c;
   logic           last_shift_c, last_all_c, use_c;
   logic           wr_en;
   logic [AW-1:0]  wr_addr, l_addr, r_addr;
   logic [sbme_pkg::PIX_W-1:0] l_data, r_data;
   logic [NCW-1:0] cnt_sum, best_new;
   logic [SW-1:0]  bests_new;
   logic           allw_new, eq;

   assign n_c        = CW'(sbme_pkg::side_clamp(int'(cfg.image_size), MAX_SIDE));
   assign m_c        = CW'(sbme_pkg::margin_clamp(int'(cfg.margin), MAX_MARGIN));
   assign limit_c    = n_c - m_c;
   assign z_c        = SW'((n_c - (m_c << 1)) >> 1);
   assign win_last_c = OW'((m_c << 1) - 1'b1);

   always_comb begin
      if (state_ff == ST_WHITE) begin
         li_c = row_ff - 1'b1 + CW'(k_ff[1]);
         lj_c = col_ff - 1'b1 + CW'(k_ff[0]);
      end else begin
         li_c = row_ff - m_c + CW'(io_ff);
         lj_c = col_ff - m_c + CW'(jo_ff);
      end
   end

   assign rr_c         = li_c + CW'(s_ff);
   assign use_c        = (rr_c <= limit_c) && (lj_c <= limit_c);
   assign last_shift_c = (io_ff == win_last_c) && (jo_ff == win_last_c);
   assign last_all_c   = last_shift_c && (s_ff == z_c - 1'b1);

   assign l_addr  = pix_addr(int'(li_c), int'(lj_c));
   assign r_addr  = pix_addr(int'(rr_c), int'(lj_c));
   assign wr_addr = pix_addr(int'(q_item.row), int'(q_item.col));
   assign wr_en   = (state_ff == ST_IDLE) && q_valid && !q_item.out_of_range &&
                    (q_item.action == sbme_pkg::ACT_LOAD);

   sbme_ram #(.WIDTH(sbme_pkg::PIX_W), .DEPTH(MAX_SIDE * MAX_SIDE)) u_left_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (q_item.left_pixel),
      .rd_addr (l_addr),
      .rd_data (l_data)
   );

   sbme_ram #(.WIDTH(sbme_pkg::PIX_W), .DEPTH(MAX_SIDE * MAX_SIDE)) u_right_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (q_item.right_pixel),
      .rd_addr (r_addr),
      .rd_data (r_data)
   );

   // Result side of the read pipeline: one compared pixel pair per cycle.
   always_comb begin
      eq        = p_use_ff && (l_data == r_data);
      cnt_sum   = cnt_ff + NCW'(eq);
      best_new  = best_ff;
      bests_new = bests_ff;
      allw_new  = allw_ff;
      if (p_valid_ff && white_mode_ff) begin
         allw_new = allw_ff && (l_data == sbme_pkg::WHITE);
      end
      if (p_valid_ff && !white_mode_ff && p_end_ff && (cnt_sum > best_ff)) begin
         best_new  = cnt_sum;
         bests_new = p_shift_ff;
      end
   end

   assign q_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      white_mode_in = white_mode_ff;
      k_in          = k_ff;
      s_in          = s_ff;
      io_in         = io_ff;
      jo_in         = jo_ff;
      p_valid_in    = 1'b0;
      p_use_in      = 1'b0;
      p_end_in      = 1'b0;
      p_shift_in    = s_ff;
      allw_in       = allw_new;
      cnt_in        = cnt_ff;
      best_in       = best_new;
      bests_in      = bests_new;
      res_shift_in  = res_shift_ff;
      res_count_in  = res_count_ff;
      res_skip_in   = res_skip_ff;
      res_oor_in    = res_oor_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      if (p_valid_ff && !white_mode_ff) begin
         cnt_in = p_end_ff ? '0 : cnt_sum;
      end

      case (state_ff)
         ST_IDLE: begin
            if (q_valid && (q_item.action == sbme_pkg::ACT_MATCH)) begin
               row_in       = CW'(q_item.row);
               col_in       = CW'(q_item.col);
               res_shift_in = '0;
               res_count_in = '0;
               res_skip_in  = 1'b0;
               res_oor_in   = 1'b0;
               s_in         = '0;
               io_in        = '0;
               jo_in        = '0;
               cnt_in       = '0;
               best_in      = '0;
               bests_in     = '0;
               if (q_item.out_of_range) begin
                  res_oor_in = 1'b1;
                  state_in   = ST_DONE;
               end else if (cfg.skip_white) begin
                  white_mode_in = 1'b1;
                  k_in          = '0;
                  allw_in       = 1'b1;
                  state_in      = ST_WHITE;
               end else begin
                  white_mode_in = 1'b0;
                  state_in      = (z_c == '0) ? ST_DONE : ST_SCAN;
               end
            end
         end
         ST_WHITE: begin
            p_valid_in = 1'b1;
            k_in       = k_ff + 1'b1;
            if (k_ff == 2'd3) begin
               state_in = ST_DRAIN;
            end
         end
         ST_SCAN: begin
            p_valid_in = 1'b1;
            p_use_in   = use_c;
            p_end_in   = last_shift_c;
            if (jo_ff == win_last_c) begin
               jo_in = '0;
               if (io_ff == win_last_c) begin
                  io_in = '0;
                  s_in  = s_ff + 1'b1;
               end else begin
                  io_in = io_ff + 1'b1;
               end
            end else begin
               jo_in = jo_ff + 1'b1;
            end
            if (last_all_c) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (white_mode_ff) begin
               white_mode_in = 1'b0;
               if (allw_new) begin
                  res_skip_in = 1'b1;
                  state_in    = ST_DONE;
               end else begin
                  s_in     = '0;
                  io_in    = '0;
                  jo_in    = '0;
                  cnt_in   = '0;
                  best_in  = '0;
                  bests_in = '0;
                  state_in = (z_c == '0) ? ST_DONE : ST_SCAN;
               end
            end else begin
               res_shift_in = sbme_pkg::SHIFT_W'(bests_new);
               res_count_in = sbme_pkg::COUNT_W'(best_new);
               state_in     = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         white_mode_ff <= 1'b0;
         p_valid_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         white_mode_ff <= white_mode_in;
         p_valid_ff    <= p_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff       <= row_in;
      col_ff       <= col_in;
      k_ff         <= k_in;
      s_ff         <= s_in;
      io_ff        <= io_in;
      jo_ff        <= jo_in;
      p_use_ff     <= p_use_in;
      p_end_ff     <= p_end_in;
      p_shift_ff   <= p_shift_in;
      allw_ff      <= allw_in;
      cnt_ff       <= cnt_in;
      best_ff      <= best_in;
      bests_ff     <= bests_in;
      res_shift_ff <= res_shift_in;
      res_count_ff <= res_count_in;
      res_skip_ff  <= res_skip_in;
      res_oor_ff   <= res_oor_in;
      if ((state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready)) begin
         rsp_shift_ff <= res_shift_ff;
         rsp_count_ff <= res_count_ff;
         rsp_skip_ff  <= res_skip_ff;
         rsp_oor_ff   <= res_oor_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_best_shift   = rsp_shift_ff;
   assign rsp_best_count   = rsp_count_ff;
   assign rsp_skipped      = rsp_skip_ff;
   assign rsp_out_of_range = rsp_oor_ff;

endmodule
`default_nettype wire

[test/stereo_block_match_equal_count_checker.sv]
`default_nettype none
module stereo_block_match_equal_count_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_write_en,
   input  wire logic [sbme_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [sbme_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                            req_tvalid,
   input  wire logic                            req_tready,
   input  wire logic [31:0]                     req_tdata,
   input  wire logic [0:0]                      req_tuser,
   input  wire logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   input  wire logic [23:0]                     rsp_tdata,
   input  wire logic [1:0]                      rsp_tuser,
   output int                                   pending,
   output int                                   failures
);

   typedef struct packed {
      logic [sbme_pkg::SHIFT_W-1:0] best_shift;
      logic [sbme_pkg::COUNT_W-1:0] best_count;
      logic                         skipped;
      logic                         out_of_range;
   } disparity_type;

   logic [sbme_pkg::PIX_W-1:0] left_store [65536];
   logic [sbme_pkg::PIX_W-1:0] right_store [65536];
   sbme_pkg::csr_type          regs;
   disparity_type              disparity_q [$];

   function automatic disparity_type match_pixel(input int r, input int c);
      disparity_type d;
      int n, m, lim, z, best, best_s, cnt, rr;
      d = '0;
      n = (regs.image_size > 256) ? 256 : int'(regs.image_size);
      m = (regs.margin < 1) ? 1 : ((regs.margin > 16) ? 16 : int'(regs.margin));
      if (n < 2*m + 1 || r < m || c < m || r >= n - m || c >= n - m) begin
         d.out_of_range = 1'b1;
         return d;
      end
      if (regs.skip_white && left_store[(r-1)*256 + c-1] == sbme_pkg::WHITE
          && left_store[(r-1)*256 + c] == sbme_pkg::WHITE
          && left_store[r*256 + c-1] == sbme_pkg::WHITE
          && left_store[r*256 + c] == sbme_pkg::WHITE) begin
         d.skipped = 1'b1;
         return d;
      end
      lim = n - m;
      z = (n - 2*m) / 2;
      best = 0;
      best_s = 0;
      for (int s = 0; s < z; s++) begin
         cnt = 0;
         for (int i = r - m; i < r + m; i++) begin
            rr = i + s;
            if (rr <= lim) begin
               for (int j = c - m; j < c + m; j++) begin
                  if (j <= lim && left_store[i*256 + j] == right_store[rr*256 + j])
                     cnt++;
               end
            end
         end
         if (cnt > best) begin
            best = cnt;
            best_s = s;
         end
      end
      d.best_shift = best_s[sbme_pkg::SHIFT_W-1:0];
      d.best_count = best[sbme_pkg::COUNT_W-1:0];
      return d;
   endfunction

   assign pending = disparity_q.size();

   always @(posedge clock) begin
      disparity_type got, want;
      if (reset) begin
         regs.image_size <= sbme_pkg::IMAGE_SIZE_RST;
         regs.margin <= sbme_pkg::MARGIN_RST;
         regs.skip_white <= 1'b0;
         disparity_q.delete();
         failures = 0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               sbme_pkg::REG_IMAGE_SIZE: regs.image_size <= csr_wdata;
               sbme_pkg::REG_MARGIN: regs.margin <= csr_wdata[sbme_pkg::MARGIN_W-1:0];
               sbme_pkg::REG_SKIP_WHITE: regs.skip_white <= csr_wdata[0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            if (sbme_pkg::action_type'(req_tuser[0]) == sbme_pkg::ACT_LOAD) begin
               left_store[{req_tdata[7:0], req_tdata[15:8]}] = req_tdata[23:16];
               right_store[{req_tdata[7:0], req_tdata[15:8]}] = req_tdata[31:24];
            end else begin
               disparity_q.push_back(match_pixel(req_tdata[7:0], req_tdata[15:8]));
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got.best_shift = rsp_tdata[6:0];
            got.best_count = rsp_tdata[17:7];
            got.skipped = rsp_tuser[0];
            got.out_of_range = rsp_tuser[1];
            if (disparity_q.size() == 0) begin
               $display("%0t: unexpected word, expected none, actual %h", $time, got);
               failures++;
            end else begin
               want = disparity_q.pop_front();
               if (got !== want) begin
                  $display("%0t: expected %0d/%0d/%b/%b, actual %0d/%0d/%b/%b",
                           $time, want.best_shift, want.best_count, want.skipped,
                           want.out_of_range, got.best_shift, got.best_count,
                           got.skipped, got.out_of_range);
                  failures++;
               end
            end
         end
      end
   end

endmodule
`default_nettype wire

[test/stereo_block_match_equal_count_tb.sv]
`default_nettype none
module stereo_block_match_equal_count_tb;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            csr_write_en = 1'b0;
   logic [sbme_pkg::CSR_IDX_W-1:0]  csr_index = sbme_pkg::REG_IMAGE_SIZE;
   logic [sbme_pkg::CSR_DATA_W-1:0] csr_wdata = '0;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [31:0]                     req_tdata = '0;
   logic [0:0]                      req_tuser = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [23:0]                     rsp_tdata;
   logic [1:0]                      rsp_tuser;
   int                              pending;
   int                              failures;
   bit                              calm = 1'b0;
   bit                              loaded [256][256];

   always #2 clock = ~clock;

   stereo_block_match_equal_count dut (.*);

   stereo_block_match_equal_count_checker u_checker (.*);

   always @(posedge clock) rsp_tready <= calm || ($urandom_range(99) >= 23);

   task automatic send_word(input sbme_pkg::action_type act, input int r, input int c,
                            input int lp, input int rp);
      while (!calm && $urandom_range(99) < 23) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= {rp[7:0], lp[7:0], c[7:0], r[7:0]};
      do @(posedge clock); while (!req_tready);
      if (act == sbme_pkg::ACT_LOAD) loaded[r][c] = 1'b1;
   endtask

   function automatic int grey_level();
      case ($urandom_range(3))
         0: return 0;
         1: return 255;
         2: return 1;
         default: return $urandom_range(255);
      endcase
   endfunction

   task automatic load_pair(input int r, input int c);
      int g;
      g = grey_level();
      send_word(sbme_pkg::ACT_LOAD, r, c, g, ($urandom_range(1) != 0) ? g : grey_level());
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_regs(input int size, input int marg, input int skip);
      settle();
      csr_write_en <= 1'b1;
      csr_index <= sbme_pkg::REG_IMAGE_SIZE;
      csr_wdata <= size[sbme_pkg::CSR_DATA_W-1:0];
      @(posedge clock);
      csr_index <= sbme_pkg::REG_MARGIN;
      csr_wdata <= marg[sbme_pkg::CSR_DATA_W-1:0];
      @(posedge clock);
      csr_index <= sbme_pkg::REG_SKIP_WHITE;
      csr_wdata <= skip[sbme_pkg::CSR_DATA_W-1:0];
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic fill_square(input int n);
      for (int r = 0; r < n; r++)
         for (int c = 0; c < n; c++)
            if (!loaded[r][c]) load_pair(r, c);
   endtask

   initial begin
      int n;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_word(sbme_pkg::ACT_MATCH, 0, 0, 0, 0);
      send_word(sbme_pkg::ACT_MATCH, 255, 255, 255, 255);
      send_word(sbme_pkg::ACT_MATCH, 3, 200, 170, 85);
      set_regs(8, 1, 1);
      calm = 1'b1;
      fill_square(8);
      for (int r = 2; r < 4; r++)
         for (int c = 2; c < 4; c++)
            send_word(sbme_pkg::ACT_LOAD, r, c, 255, 255);
      send_word(sbme_pkg::ACT_LOAD, 255, 255, 170, 85);
      send_word(sbme_pkg::ACT_LOAD, 254, 0, 85, 170);
      send_word(sbme_pkg::ACT_MATCH, 3, 3, 0, 0);
      send_word(sbme_pkg::ACT_MATCH, 1, 1, 0, 0);
      send_word(sbme_pkg::ACT_MATCH, 6, 6, 0, 0);
      send_word(sbme_pkg::ACT_MATCH, 7, 3, 0, 0);
      calm = 1'b0;
      set_regs(8, 1, 0);
      send_word(sbme_pkg::ACT_MATCH, 3, 3, 0, 0);
      send_word(sbme_pkg::ACT_MATCH, 4, 5, 0, 0);
      set_regs(5, 2, 0);
      send_word(sbme_pkg::ACT_MATCH, 2, 2, 0, 0);
      set_regs(4, 0, 0);
      send_word(sbme_pkg::ACT_MATCH, 1, 1, 0, 0);
      send_word(sbme_pkg::ACT_MATCH, 2, 2, 0, 0);
      for (int ph = 0; ph < 7; ph++) begin
         n = $urandom_range(5, 12);
         set_regs(n, ($urandom_range(7) == 0) ? $urandom_range(17, 31) : $urandom_range(0, 5),
                  $urandom_range(1));
         fill_square(n);
         calm = (ph == 3);
         for (int k = 0; k < 18; k++) begin
            if ($urandom_range(3) == 0)
               load_pair($urandom_range(n - 1), $urandom_range(n - 1));
            else if ($urandom_range(4) == 0)
               send_word(sbme_pkg::ACT_MATCH, $urandom_range(255), $urandom_range(255),
                         $urandom_range(255), $urandom_range(255));
            else
               send_word(sbme_pkg::ACT_MATCH, $urandom_range(n - 1), $urandom_range(n - 1),
                         0, 0);
         end
         calm = 1'b0;
      end
      set_regs(511, 31, 1);
      send_word(sbme_pkg::ACT_MATCH, 15, 100, 0, 0);
      send_word(sbme_pkg::ACT_MATCH, 100, 240, 0, 0);
      set_regs(256, 16, 0);
      send_word(sbme_pkg::ACT_MATCH, 255, 0, 0, 0);
      settle();
      if (failures == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #4000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
`default_nettype wire
